// ===== rtl/sorted_deadline_alarm_queue_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sorted deadline alarm queue unit.
// Concurrent checks on clk_i, optionally gated by the active-low reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_DEADLINE_ALARM_QUEUE_UNIT_MACROS_SVH
`define SORTED_DEADLINE_ALARM_QUEUE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only while the block is out of reset.
`define SDAQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define SDAQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SDAQ_ASSERT(label, prop, msg)
`define SDAQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/sdaq_pkg.sv =====
// ---------------------------------------------------------------------------
// sdaq_pkg
// Shared types and codes of the sorted deadline alarm queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdaq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_EXPIRED  = 2'd2
  } kind_e;

  // One queue entry as held by a cell.
  typedef struct packed {
    logic        valid;
    logic [31:0] deadline;
    logic [15:0] seconds;
    logic [15:0] tag;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic pop;
  } ctrl_t;

endpackage

// ===== rtl/sdaq_cell.sv =====
// ---------------------------------------------------------------------------
// sdaq_cell
// One slot of the sorted chain: keeps its entry, takes the new entry,
// takes its left neighbor on an insert shift or its right neighbor on a pop.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdaq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sdaq_pkg::ctrl_t  ctrl_i,
  input  sdaq_pkg::entry_t new_i,
  input  sdaq_pkg::entry_t prev_i,
  input  logic            prev_ge_i,
  input  sdaq_pkg::entry_t next_i,
  output sdaq_pkg::entry_t cell_o,
  output logic            ge_o
);
  import sdaq_pkg::*;

  entry_t cell_q;
  entry_t cell_d;
  logic   take_new;

  // Sorted chain: ge_o is zero up to the insert point, then one while valid.
  assign ge_o = cell_q.valid && (cell_q.deadline >= new_i.deadline);

  // The new entry lands in the first cell at or after its deadline, or in the
  // first empty cell when every stored deadline is earlier.
  assign take_new = !prev_ge_i && (ge_o || (!cell_q.valid && prev_i.valid));

  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.ins) begin
      if (prev_ge_i) begin
        cell_d = prev_i;
      end else if (take_new) begin
        cell_d = new_i;
      end
    end else if (ctrl_i.pop) begin
      cell_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== rtl/sorted_deadline_alarm_queue_unit.sv =====
// ---------------------------------------------------------------------------
// sorted_deadline_alarm_queue_unit
// Deadline-ordered alarm queue built as a chain of cells plus a held slot.
// ---------------------------------------------------------------------------
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   op, delay_seconds, msg_tag
//   out      output     out_valid_o / out_stall_i kind, out_seconds, out_tag, last
//
// An insert shifts the cell chain or fills the held slot when it is taken; a
// full rejection leaves both. Either then issues its status transfer once the
// output is free. A tick advances time when taken; each alarm that a tick or
// an insert releases then moves in turn into the pending result register, and
// the final result is handed on. Reset clears time, held slot and all cell
// valid bits at once. Output stalls hold the drain; a new input is taken once
// the last result of the previous item, if any, sits in the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_deadline_alarm_queue_unit_macros.svh"

module sorted_deadline_alarm_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = sdaq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [15:0] delay_seconds_i,
  input  logic [15:0] msg_tag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] out_seconds_o,
  output logic [15:0] out_tag_o,
  output logic        last_o
);
  import sdaq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  state_e      state_q;
  logic [31:0] now_q;

  logic        held_valid_q;
  logic [31:0] held_deadline_q;
  logic [15:0] held_seconds_q;
  logic [15:0] held_tag_q;

  logic        pend_valid_q;
  kind_e       pend_kind_q;
  logic [15:0] pend_seconds_q;
  logic [15:0] pend_tag_q;

  logic        out_valid_q;
  kind_e       out_kind_q;
  logic [15:0] out_seconds_q;
  logic [15:0] out_tag_q;
  logic        out_last_q;

  entry_t                 cell_w [QUEUE_DEPTH];
  entry_t                 prev_w [QUEUE_DEPTH];
  entry_t                 next_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ge_w;
  logic [QUEUE_DEPTH-1:0] prev_ge_w;

  entry_t new_entry;
  ctrl_t  ctrl;
  logic   accept;
  logic   full;
  logic   out_free;
  logic   held_due;
  logic   advance;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign full      = cell_w[QUEUE_DEPTH-1].valid;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign held_due  = held_valid_q && (held_deadline_q <= now_q);
  // A drain step runs when there is no pending result or it can be handed on.
  assign advance   = (state_q == ST_DRAIN) && (!pend_valid_q || out_free);

  assign new_entry.valid    = 1'b1;
  assign new_entry.deadline = now_q + {16'b0, delay_seconds_i};
  assign new_entry.seconds  = delay_seconds_i;
  assign new_entry.tag      = msg_tag_i;

  // With the held slot empty the chain is empty too, so the insert goes there.
  assign ctrl.ins = accept && (op_i == OP_INSERT) && held_valid_q && !full;
  assign ctrl.pop = advance && held_due && cell_w[0].valid;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      // The slot left of the head counts as occupied and never shifts.
      assign prev_w[g]    = '{valid: 1'b1, deadline: '0, seconds: '0, tag: '0};
      assign prev_ge_w[g] = 1'b0;
    end else begin : g_inner
      assign prev_w[g]    = cell_w[g-1];
      assign prev_ge_w[g] = ge_w[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign next_w[g] = '{valid: 1'b0, deadline: '0, seconds: '0, tag: '0};
    end else begin : g_body
      assign next_w[g] = cell_w[g+1];
    end

    sdaq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_i     (new_entry),
      .prev_i    (prev_w[g]),
      .prev_ge_i (prev_ge_w[g]),
      .next_i    (next_w[g]),
      .cell_o    (cell_w[g]),
      .ge_o      (ge_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      now_q           <= '0;
      held_valid_q    <= 1'b0;
      held_deadline_q <= '0;
      held_seconds_q  <= '0;
      held_tag_q      <= '0;
      pend_valid_q    <= 1'b0;
      pend_kind_q     <= KIND_ACCEPTED;
      pend_seconds_q  <= '0;
      pend_tag_q      <= '0;
      out_valid_q     <= 1'b0;
      out_kind_q      <= KIND_ACCEPTED;
      out_seconds_q   <= '0;
      out_tag_q       <= '0;
      out_last_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !(advance && pend_valid_q)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q        <= ST_DRAIN;
            pend_seconds_q <= delay_seconds_i;
            pend_tag_q     <= msg_tag_i;
            if (op_i == OP_TICK) begin
              now_q        <= now_q + 32'd1;
              pend_valid_q <= 1'b0;
            end else if (full) begin
              pend_valid_q <= 1'b1;
              pend_kind_q  <= KIND_FULL;
            end else begin
              pend_valid_q <= 1'b1;
              pend_kind_q  <= KIND_ACCEPTED;
              if (!held_valid_q) begin
                held_valid_q    <= 1'b1;
                held_deadline_q <= new_entry.deadline;
                held_seconds_q  <= delay_seconds_i;
                held_tag_q      <= msg_tag_i;
              end
            end
          end
        end
        ST_DRAIN: begin
          if (advance) begin
            if (pend_valid_q) begin
              out_valid_q   <= 1'b1;
              out_kind_q    <= pend_kind_q;
              out_seconds_q <= pend_seconds_q;
              out_tag_q     <= pend_tag_q;
              out_last_q    <= !held_due;
            end
            if (held_due) begin
              // Fire the held alarm and refill the slot from the chain head.
              pend_valid_q   <= 1'b1;
              pend_kind_q    <= KIND_EXPIRED;
              pend_seconds_q <= held_seconds_q;
              pend_tag_q     <= held_tag_q;
              if (cell_w[0].valid) begin
                held_deadline_q <= cell_w[0].deadline;
                held_seconds_q  <= cell_w[0].seconds;
                held_tag_q      <= cell_w[0].tag;
              end else begin
                held_valid_q <= 1'b0;
              end
            end else begin
              pend_valid_q <= 1'b0;
              state_q      <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign out_seconds_o = out_seconds_q;
  assign out_tag_o     = out_tag_q;
  assign last_o        = out_last_q;

  `SDAQ_ASSERT_ALWAYS(a_held_before_head, !held_valid_q |-> !cell_w[0].valid,
                      "chain head occupied while the held slot is empty")
  `SDAQ_ASSERT(a_full_has_held, cell_w[QUEUE_DEPTH-1].valid |-> held_valid_q,
               "full chain without a held alarm")
  `SDAQ_ASSERT(a_idle_not_due, (state_q == ST_IDLE && held_valid_q) |->
               (held_deadline_q > now_q), "due alarm left in the held slot at idle")
  `SDAQ_ASSERT(a_pend_in_drain, pend_valid_q |-> (state_q == ST_DRAIN),
               "pending result outside the drain")

endmodule

// ===== verif/tb_sorted_deadline_alarm_queue_unit.sv =====
// ---------------------------------------------------------------------------
// tb_sorted_deadline_alarm_queue_unit
// Self-checking testbench for the deadline-ordered alarm queue. A scoreboard
// tracks time, the sorted entries and the held slot. It forecasts the status
// and expiry transfers of every accepted item, and a monitor compares each
// output transfer with them. Directed cases are followed by randomized
// traffic, with random input gaps and output stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_deadline_alarm_queue_unit;
  import sdaq_pkg::*;

  localparam int unsigned DEPTH        = QUEUE_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned REPORT_CAP   = 40;

  typedef struct packed {
    logic [31:0] deadline;
    logic [15:0] seconds;
    logic [15:0] tag;
  } alarm_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] seconds;
    logic [15:0] tag;
    logic        last;
  } alarm_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        in_op      = 1'b0;
  logic [15:0] in_delay   = '0;
  logic [15:0] in_tag     = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [1:0]  res_kind;
  logic [15:0] res_seconds;
  logic [15:0] res_tag;
  logic        res_last;

  // Scoreboard copy of the queue state.
  alarm_t        sorted_alarms [DEPTH];
  int            alarm_count  = 0;
  logic [31:0]   clock_now    = '0;
  logic          held_busy    = 1'b0;
  alarm_t        held_alarm   = '0;
  alarm_result_t due_results [$];

  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  bit          gaps_on      = 1'b1;
  bit          hold_request = 1'b0;
  logic [15:0] prev_delay   = 16'd3;

  int unsigned inserts_done = 0;
  int unsigned ticks_done   = 0;
  int unsigned refusals     = 0;
  int unsigned alarms_fired = 0;
  int unsigned widest_burst = 0;
  int unsigned long_holds   = 0;

  sorted_deadline_alarm_queue_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (in_op),
    .delay_seconds_i(in_delay),
    .msg_tag_i      (in_tag),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (res_kind),
    .out_seconds_o  (res_seconds),
    .out_tag_o      (res_tag),
    .last_o         (res_last)
  );

  always #4 clk = ~clk;

  // Applies one accepted item to the scoreboard and queues the transfers it causes.
  function automatic void forecast_item(op_e op_v, logic [15:0] secs_v, logic [15:0] tag_v);
    alarm_result_t batch [DEPTH + 1];
    int            n;
    int            pos;
    logic [31:0]   dl;
    bit            fire;
    n = 0;
    if (op_v == OP_INSERT && alarm_count >= DEPTH) begin
      batch[0] = '{KIND_FULL, secs_v, tag_v, 1'b0};
      n = 1;
      refusals++;
    end else begin
      if (op_v == OP_INSERT) begin
        dl  = clock_now + 32'(secs_v);
        pos = 0;
        // Ties land in front of older entries, so they fire newest first.
        while (pos < alarm_count && sorted_alarms[pos].deadline < dl) pos++;
        for (int i = alarm_count; i > pos; i--) sorted_alarms[i] = sorted_alarms[i - 1];
        sorted_alarms[pos] = '{dl, secs_v, tag_v};
        alarm_count++;
        batch[0] = '{KIND_ACCEPTED, secs_v, tag_v, 1'b0};
        n = 1;
        inserts_done++;
      end else begin
        clock_now++;
        ticks_done++;
      end
      do begin
        if (!held_busy && alarm_count > 0) begin
          held_alarm = sorted_alarms[0];
          for (int i = 1; i < alarm_count; i++) sorted_alarms[i - 1] = sorted_alarms[i];
          alarm_count--;
          held_busy = 1'b1;
        end
        fire = held_busy && (held_alarm.deadline <= clock_now);
        if (fire) begin
          batch[n] = '{KIND_EXPIRED, held_alarm.seconds, held_alarm.tag, 1'b0};
          n++;
          held_busy = 1'b0;
        end
      end while (fire);
    end
    for (int k = 0; k < n; k++) begin
      batch[k].last = (k == n - 1);
      due_results.push_back(batch[k]);
    end
    if (n > widest_burst) widest_burst = n;
  endfunction

  // Offers one item and returns once it is transferred, then maybe opens a gap.
  task automatic send_item(op_e op_v, logic [15:0] secs_v, logic [15:0] tag_v);
    in_valid <= 1'b1;
    in_op    <= op_v;
    in_delay <= secs_v;
    in_tag   <= tag_v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    forecast_item(op_v, secs_v, tag_v);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      in_op    <= 1'($urandom_range(1));
      in_delay <= 16'($urandom);
      in_tag   <= 16'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 10);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Always waits on a clock edge before it checks the queue, so the next drive lands in a later step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_item(int unsigned insert_pct);
    logic [15:0] secs;
    if ($urandom_range(99) < insert_pct) begin
      if (alarm_count >= DEPTH) begin
        secs = 16'($urandom);
      end else if ($urandom_range(99) < 2) begin
        secs = 16'($urandom_range(16'hFFFF, 16'h1000));
      end else if ($urandom_range(99) < 20) begin
        secs = prev_delay;
      end else begin
        secs = 16'($urandom_range(0, 12));
      end
      prev_delay = (secs > 16'd12) ? prev_delay : secs;
      send_item(OP_INSERT, secs, 16'($urandom));
    end else begin
      send_item(OP_TICK, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_idle_ticks();
    send_item(OP_TICK, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'hFFFF, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_immediate_expiry();
    send_item(OP_INSERT, 16'd0, 16'hFFFF);
    send_item(OP_INSERT, 16'd0, 16'h0000);
    wait_drained();
  endtask

  // An earlier deadline inserted later must wait behind the held alarm.
  task automatic test_held_slot_priority();
    send_item(OP_INSERT, 16'd4, 16'h1111);
    send_item(OP_INSERT, 16'd1, 16'h2222);
    repeat (4) send_item(OP_TICK, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  // Fill held slot and queue with one deadline, refuse two more, then release all in one tick.
  task automatic test_full_and_tie_burst();
    send_item(OP_INSERT, 16'd1, 16'h0100);
    for (int i = 0; i < DEPTH; i++) send_item(OP_INSERT, 16'd1, 16'(16'h0101 + i));
    send_item(OP_INSERT, 16'hFFFF, 16'h0000);
    send_item(OP_INSERT, 16'h0000, 16'hFFFF);
    send_item(OP_TICK, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  // The receiver holds off while items keep coming, so the input must stall.
  task automatic test_output_backpressure();
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) send_item(OP_TICK, 16'($urandom), 16'($urandom));
      else send_item(OP_INSERT, 16'($urandom_range(0, 3)), 16'($urandom));
    end
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned round_len;
    int unsigned insert_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      round_len = $urandom_range(15, 40);
      case ($urandom_range(2))
        0:       insert_pct = 30;
        1:       insert_pct = 55;
        default: insert_pct = 85;
      endcase
      gaps_on = ($urandom_range(3) != 0);
      repeat (round_len) begin
        random_item(insert_pct);
        sent++;
      end
      if ($urandom_range(3) == 0) wait_drained();
    end
    wait_drained();
    gaps_on = 1'b1;
  endtask

  function automatic void check_field(string field, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    alarm_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        fail_count++;
        $error("unexpected result: kind %0d seconds 0x%0h tag 0x%0h", res_kind,
               res_seconds, res_tag);
      end else begin
        want = due_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(res_kind));
        check_field("out_seconds", want.seconds, res_seconds);
        check_field("out_tag", want.tag, res_tag);
        check_field("last", 16'(want.last), 16'(res_last));
        if (want.kind == KIND_EXPIRED) alarms_fired++;
      end
    end
  end

  // Output stall pattern: spans of a repeating 8-bit pattern, some of them stall-free.
  initial begin : out_stall_pattern
    logic [7:0]  pat;
    int unsigned span;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      span = $urandom_range(4, 40);
      pat  = ($urandom_range(3) == 0) ? 8'h00 : (8'($urandom) & 8'hFE);
      for (int k = 0; k < span; k++) begin
        if (hold_request) begin
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
          hold_request = 1'b0;
          long_holds++;
        end
        out_stall <= pat[k % 8];
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sorted_deadline_alarm_queue_unit regression: fail");
    $finish;
  end

  initial begin : test_sequence
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_immediate_expiry();
    test_held_slot_priority();
    test_full_and_tie_burst();
    test_output_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (DEPTH + 8) @(posedge clk);
    $display("Run covered %0d accepted inserts, %0d refused while full, %0d ticks, %0d alarms fired.",
             inserts_done, refusals, ticks_done, alarms_fired);
    $display("Most transfers from one item: %0d; long output hold-offs: %0d.",
             widest_burst, long_holds);
    if (fail_count == 0) begin
      $display("sorted_deadline_alarm_queue_unit regression: pass");
    end else begin
      $display("sorted_deadline_alarm_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
